### hw/rtl/assert_macros.svh
// assertion macros used by bitmap_first_free_allocator
// each macro expects clk and arst_n in scope; empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_SAME(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hw/rtl/bffa_pkg.sv
// types and constants of the first-free bitmap allocator
// no dependencies
package bffa_pkg;

	localparam int IDX_W = 10;
	localparam int IDX_SPAN = 1024;
	localparam int CFG_W = 11;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [CFG_W-1:0] USABLE_RESET = CFG_W'(1024);

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	localparam logic REG_USABLE = 1'b0;

	typedef struct packed {
		logic cmd;
		logic [IDX_W-1:0] entry_index;
	} req_beat_t;

	typedef struct packed {
		logic [IDX_W-1:0] granted_index;
		logic [1:0] status;
	} rsp_beat_t;

endpackage

### hw/rtl/bitmap_first_free_allocator.sv
// first-free bitmap allocator; depends on bffa_pkg, bffa_map_ram and assert_macros.svh
// allocate scans one map word per cycle, checks each word read and sets and grants its lowest free
// bit, or gives STATUS_FULL when no entry below the limit is free; free of an in-range entry seeks
// its word, reads it and clears the bit in ST_CLR; one beat at a time, the next can be taken in the
// cycle after the response is loaded; a response not yet taken by rsp_ready stalls the next one
// reset clears the whole map through per-word valid bits and sets usable_q to 1024
`include "assert_macros.svh"

module bitmap_first_free_allocator
	import bffa_pkg::*;
#(
	parameter int ENTRIES = 1024,
	parameter int WORD_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input req_beat_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output rsp_beat_t rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [APB_AW-1:0] paddr,
	input logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic pready
);

	localparam int SPAN = (ENTRIES < IDX_SPAN) ? ENTRIES : IDX_SPAN;
	localparam int MAP_WORDS = (SPAN + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BW = $clog2(WORD_BITS);
	localparam logic [CFG_W-1:0] WB = CFG_W'(WORD_BITS);
	localparam logic [CFG_W-1:0] SPAN_C = CFG_W'(SPAN);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SEEK,
		ST_CLR,
		ST_RESP
	} state_t;

	state_t state_q;
	logic [CFG_W-1:0] usable_q;
	logic [IDX_W-1:0] idx_q;
	logic [AW-1:0] w_q;
	logic [CFG_W-1:0] base_q;
	logic chk_live_q;
	logic [AW-1:0] chk_w_q;
	logic [CFG_W-1:0] chk_base_q;
	logic [BW-1:0] bit_q;
	logic [IDX_W-1:0] res_idx_q;
	logic [1:0] res_status_q;
	logic rsp_valid_q;
	rsp_beat_t rsp_q;

	logic [CFG_W-1:0] lim;
	logic [CFG_W-1:0] room;
	logic [CFG_W-1:0] offset;
	logic [WORD_BITS-1:0] rd_data;
	logic [WORD_BITS-1:0] free_bits;
	logic [BW-1:0] pos;
	logic found;
	logic last_word;
	logic issue;
	logic seek_hit;
	logic ram_rd_en;
	logic ram_wr_en;
	logic [AW-1:0] ram_wr_addr;
	logic [WORD_BITS-1:0] ram_wr_data;
	logic req_fire;
	logic cfg_wr;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_USABLE);
	assign prdata = (paddr[2] == REG_USABLE) ? APB_DW'(usable_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_q <= USABLE_RESET;
		end else if (cfg_wr) begin
			usable_q <= pwdata[CFG_W-1:0];
		end
	end

	assign lim = (usable_q < SPAN_C) ? usable_q : SPAN_C;

	// word check
	assign room = lim - chk_base_q;
	always_comb begin
		free_bits = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			free_bits[b] = !rd_data[b] && (CFG_W'(b) < room);
		end
	end

	always_comb begin
		pos = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				pos = BW'(b);
			end
		end
	end

	assign found = |free_bits;
	assign last_word = (room <= WB);
	assign issue = (state_q == ST_SCAN) && (base_q < lim);
	assign offset = {1'b0, idx_q} - base_q;
	assign seek_hit = (state_q == ST_SEEK) && (offset < WB);

	assign ram_rd_en = issue || seek_hit;
	assign ram_wr_en = ((state_q == ST_SCAN) && chk_live_q && found) || (state_q == ST_CLR);
	assign ram_wr_addr = (state_q == ST_SCAN) ? chk_w_q : w_q;
	assign ram_wr_data = (state_q == ST_SCAN) ?
		(rd_data | (WORD_BITS'(1) << pos)) :
		(rd_data & ~(WORD_BITS'(1) << bit_q));

	bffa_map_ram #(
		.DEPTH(MAP_WORDS),
		.WIDTH(WORD_BITS),
		.AW(AW)
	) u_map (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(ram_rd_en),
		.rd_addr(w_q),
		.rd_data(rd_data),
		.wr_en(ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			w_q <= '0;
			base_q <= '0;
			chk_live_q <= 1'b0;
			chk_w_q <= '0;
			chk_base_q <= '0;
			bit_q <= '0;
			res_idx_q <= '0;
			res_status_q <= STATUS_OK;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					chk_live_q <= 1'b0;
					if (req_fire) begin
						idx_q <= req.entry_index;
						w_q <= '0;
						base_q <= '0;
						res_idx_q <= '0;
						if (req.cmd == CMD_ALLOC) begin
							if (lim == '0) begin
								res_status_q <= STATUS_FULL;
								state_q <= ST_RESP;
							end else begin
								state_q <= ST_SCAN;
							end
						end else if ({1'b0, req.entry_index} >= lim) begin
							res_status_q <= STATUS_RANGE;
							state_q <= ST_RESP;
						end else begin
							state_q <= ST_SEEK;
						end
					end
				end
				ST_SCAN: begin
					chk_live_q <= issue;
					chk_w_q <= w_q;
					chk_base_q <= base_q;
					if (issue) begin
						w_q <= w_q + AW'(1);
						base_q <= base_q + WB;
					end
					if (chk_live_q) begin
						if (found) begin
							res_idx_q <= IDX_W'(chk_base_q + CFG_W'(pos));
							res_status_q <= STATUS_OK;
							chk_live_q <= 1'b0;
							state_q <= ST_RESP;
						end else if (last_word) begin
							res_status_q <= STATUS_FULL;
							chk_live_q <= 1'b0;
							state_q <= ST_RESP;
						end
					end
				end
				ST_SEEK: begin
					if (seek_hit) begin
						bit_q <= offset[BW-1:0];
						state_q <= ST_CLR;
					end else begin
						w_q <= w_q + AW'(1);
						base_q <= base_q + WB;
					end
				end
				ST_CLR: begin
					res_status_q <= STATUS_OK;
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						rsp_q.granted_index <= res_idx_q;
						rsp_q.status <= res_status_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	`ASSERT_SAME(a_scan_in_range, (state_q == ST_SCAN) && chk_live_q, chk_base_q < lim)
	`ASSERT_NEXT(a_accept_leaves_idle, req_fire, state_q != ST_IDLE)
	`ASSERT_SAME(a_write_phase, ram_wr_en, (state_q == ST_SCAN) || (state_q == ST_CLR))
	`ASSERT_SAME(a_grant_in_range, rsp_valid_q && (rsp_q.status == STATUS_OK),
		{1'b0, rsp_q.granted_index} < lim)

endmodule

### hw/rtl/bffa_map_ram.sv
// bitmap word memory with one valid bit per word, cleared at reset
// words never written read as zero; depends on nothing
module bffa_map_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	parameter int AW = 5
) (
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input logic [AW-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rd_data_s1;
	logic rd_valid_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s1 <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_s1 ? rd_data_s1 : '0;

endmodule
